// File: design/ecal_pkg.sv
package ecal_pkg;

  // data path width of the shared compare-subtract unit
  localparam int unsigned AluW = 31;

  // divisors for the restoring divisions
  localparam logic [AluW-1:0] DAY_SECS  = 31'd86400;
  localparam logic [AluW-1:0] SIXTY     = 31'd60;
  localparam logic [AluW-1:0] WEEK_DAYS = 31'd7;

  // year lengths
  localparam logic [AluW-1:0] LEAP_YEAR_DAYS  = 31'd366;
  localparam logic [AluW-1:0] PLAIN_YEAR_DAYS = 31'd365;

  // top quotient bit of each division
  localparam logic [3:0] DAY_TOP_BIT  = 4'd14;
  localparam logic [3:0] MIN_TOP_BIT  = 4'd10;
  localparam logic [3:0] HOUR_TOP_BIT = 4'd4;
  localparam logic [3:0] WDAY_TOP_BIT = 4'd11;

  localparam logic [7:0]  BASE_YEAR     = 8'd70;
  localparam logic [30:0] EPOCH_WEEKDAY = 31'd4;
  localparam logic [3:0]  LAST_MONTH    = 4'd11;

  // month indexes, january is zero
  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_APR = 4'd3;
  localparam logic [3:0] MON_JUN = 4'd5;
  localparam logic [3:0] MON_SEP = 4'd8;
  localparam logic [3:0] MON_NOV = 4'd10;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] month_day;
    logic [3:0] month;
    logic [7:0] year_since_1900;
  } ecal_result_t;

  // days in a month, zero-based month index
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: design/ecal_sub.sv
module ecal_sub
  import ecal_pkg::*;
(
  input  logic [AluW-1:0] a_i,
  input  logic [AluW-1:0] b_i,
  output logic [AluW-1:0] diff_o,
  output logic            ge_o
);

  logic [AluW:0] wide;

  // one subtract, borrow out gives the compare
  assign wide   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = wide[AluW-1:0];
  assign ge_o   = ~wide[AluW];

endmodule

// File: design/ecal_ctrl.sv
module ecal_ctrl
  import ecal_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [30:0]  secs_i,
  output logic         busy_o,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output ecal_result_t res_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DAY, ST_MIN, ST_HOUR, ST_WDAY, ST_YEAR, ST_MONTH, ST_DONE
  } state_e;

  state_e          state_q;
  logic [AluW-1:0] rem_q;
  logic [14:0]     quo_q;
  logic [3:0]      bit_q;
  logic [14:0]     days_q;
  logic [5:0]      sec_q;
  logic [5:0]      min_q;
  logic [4:0]      hour_q;
  logic [2:0]      wday_q;
  logic [7:0]      yr_q;
  logic [3:0]      mon_q;

  logic [AluW-1:0] sub_b;
  logic [AluW-1:0] diff;
  logic            ge;
  logic [AluW-1:0] rem_step;
  logic [14:0]     quo_d;
  logic            leap;

  assign leap = (yr_q[1:0] == 2'd0);

  // operand select for the shared unit
  always_comb begin
    unique case (state_q)
      ST_DAY:         sub_b = DAY_SECS << bit_q;
      ST_MIN,
      ST_HOUR:        sub_b = SIXTY << bit_q;
      ST_WDAY:        sub_b = WEEK_DAYS << bit_q;
      ST_YEAR:        sub_b = leap ? LEAP_YEAR_DAYS : PLAIN_YEAR_DAYS;
      ST_MONTH:       sub_b = AluW'(month_len(mon_q, leap));
      ST_IDLE,
      ST_DONE:        sub_b = '0;
      default:        sub_b = '0;
    endcase
  end

  ecal_sub u_sub (
    .a_i    (rem_q),
    .b_i    (sub_b),
    .diff_o (diff),
    .ge_o   (ge)
  );

  // restoring division step
  assign rem_step = ge ? diff : rem_q;
  assign quo_d    = {quo_q[13:0], ge};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
      quo_q   <= '0;
      bit_q   <= '0;
      days_q  <= '0;
      sec_q   <= '0;
      min_q   <= '0;
      hour_q  <= '0;
      wday_q  <= '0;
      yr_q    <= '0;
      mon_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            rem_q   <= secs_i;
            quo_q   <= '0;
            bit_q   <= DAY_TOP_BIT;
            state_q <= ST_DAY;
          end
        end
        // seconds to days, remainder is second of day
        ST_DAY: begin
          if (bit_q == 4'd0) begin
            rem_q   <= rem_step;
            days_q  <= quo_d;
            quo_q   <= '0;
            bit_q   <= MIN_TOP_BIT;
            state_q <= ST_MIN;
          end else begin
            rem_q <= rem_step;
            quo_q <= quo_d;
            bit_q <= bit_q - 4'd1;
          end
        end
        // second of day to minutes
        ST_MIN: begin
          if (bit_q == 4'd0) begin
            sec_q   <= rem_step[5:0];
            rem_q   <= AluW'(quo_d[10:0]);
            quo_q   <= '0;
            bit_q   <= HOUR_TOP_BIT;
            state_q <= ST_HOUR;
          end else begin
            rem_q <= rem_step;
            quo_q <= quo_d;
            bit_q <= bit_q - 4'd1;
          end
        end
        // minutes to hours
        ST_HOUR: begin
          if (bit_q == 4'd0) begin
            min_q   <= rem_step[5:0];
            hour_q  <= quo_d[4:0];
            rem_q   <= AluW'(days_q) + EPOCH_WEEKDAY;
            quo_q   <= '0;
            bit_q   <= WDAY_TOP_BIT;
            state_q <= ST_WDAY;
          end else begin
            rem_q <= rem_step;
            quo_q <= quo_d;
            bit_q <= bit_q - 4'd1;
          end
        end
        // day count plus the epoch weekday, mod 7, for the weekday
        ST_WDAY: begin
          if (bit_q == 4'd0) begin
            wday_q  <= rem_step[2:0] + 3'd1;
            rem_q   <= AluW'(days_q);
            yr_q    <= BASE_YEAR;
            state_q <= ST_YEAR;
          end else begin
            rem_q <= rem_step;
            quo_q <= quo_d;
            bit_q <= bit_q - 4'd1;
          end
        end
        // strip whole years
        ST_YEAR: begin
          if (ge) begin
            rem_q <= diff;
            yr_q  <= yr_q + 8'd1;
          end else begin
            mon_q   <= '0;
            state_q <= ST_MONTH;
          end
        end
        // strip whole months, december takes the rest
        ST_MONTH: begin
          if (mon_q == LAST_MONTH || !ge) begin
            state_q <= ST_DONE;
          end else begin
            rem_q <= diff;
            mon_q <= mon_q + 4'd1;
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    res_o.second          = sec_q;
    res_o.minute          = min_q;
    res_o.hour            = hour_q;
    res_o.weekday         = wday_q;
    res_o.month_day       = rem_q[4:0] + 5'd1;
    res_o.month           = mon_q + 4'd1;
    res_o.year_since_1900 = yr_q;
  end

endmodule

// File: design/epoch_seconds_to_calendar_top.sv
// channel | signals                                  | direction
// in      | in_valid_i, in_stall_o, epoch_seconds_i  | one transaction in per conversion
// out     | out_valid_o, out_stall_i, second_o ..    | one transaction out per conversion
//
// one conversion runs four restoring divisions (15 + 11 + 5 + 12 steps), then one
// compare-subtract per year stripped plus a closing compare, and one per month stripped
// (up to 11) plus one, all through one shared 31-bit compare-subtract unit; the result
// then moves to the output register when that register can take it, and the next input
// is taken only once the sequencer is back in idle.
// in_stall_o is high from the input transaction until the result moves to the output
// register; the next transaction is taken while that register waits for out_stall_i.
// rst_ni clears the sequencer and the output valid asynchronously.
module epoch_seconds_to_calendar_top
  import ecal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [30:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [2:0]  weekday_o,
  output logic [4:0]  month_day_o,
  output logic [3:0]  month_o,
  output logic [7:0]  year_since_1900_o
);

  logic         busy;
  logic         res_valid;
  logic         res_ready;
  ecal_result_t res;
  ecal_result_t out_q;
  logic         out_valid_q;

  assign in_stall_o = busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  ecal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !busy),
    .secs_i      (epoch_seconds_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign second_o          = out_q.second;
  assign minute_o          = out_q.minute;
  assign hour_o            = out_q.hour;
  assign weekday_o         = out_q.weekday;
  assign month_day_o       = out_q.month_day;
  assign month_o           = out_q.month;
  assign year_since_1900_o = out_q.year_since_1900;

endmodule
